### hw/rtl/uri_query_option_parser_defines.svh
// ----------------------------------------------------------------------------
// uri_query_option_parser_defines.svh
// Assertion macros used by the URI query option parser top module.
// ----------------------------------------------------------------------------
`ifndef URI_QUERY_OPTION_PARSER_DEFINES_SVH
`define URI_QUERY_OPTION_PARSER_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define UQP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define UQP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/uqp_pkg.sv
// ----------------------------------------------------------------------------
// uqp_pkg
// Types, character codes and helper functions of the URI query option parser.
// ----------------------------------------------------------------------------
package uqp_pkg;

  // Parse phases, one-hot
  typedef enum logic [11:0] {
    PH_SEEK   = 12'b0000_0000_0001,
    PH_AFTERQ = 12'b0000_0000_0010,
    PH_LETTER = 12'b0000_0000_0100,
    PH_EQ     = 12'b0000_0000_1000,
    PH_NFIRST = 12'b0000_0001_0000,
    PH_NWS    = 12'b0000_0010_0000,
    PH_NSIGN  = 12'b0000_0100_0000,
    PH_NZERO  = 12'b0000_1000_0000,
    PH_NHEX0  = 12'b0001_0000_0000,
    PH_NDIG   = 12'b0010_0000_0000,
    PH_SUFFIX = 12'b0100_0000_0000,
    PH_DONE   = 12'b1000_0000_0000
  } phase_e;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_e;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_K_LO  = 8'h6B;
  localparam logic [7:0] CH_K_UP  = 8'h4B;
  localparam logic [7:0] CH_M_LO  = 8'h6D;
  localparam logic [7:0] CH_M_UP  = 8'h4D;
  localparam logic [7:0] CH_G_LO  = 8'h67;
  localparam logic [7:0] CH_G_UP  = 8'h47;
  localparam logic [7:0] CH_R_LO  = 8'h72;
  localparam logic [7:0] CH_R_UP  = 8'h52;

  // Option letters
  localparam logic [7:0] LTR_SIZE   = 8'h73; // s
  localparam logic [7:0] LTR_CODE   = 8'h72; // r
  localparam logic [7:0] LTR_DELAY  = 8'h74; // t
  localparam logic [7:0] LTR_WAIT   = 8'h77; // w
  localparam logic [7:0] LTR_CACHE  = 8'h63; // c
  localparam logic [7:0] LTR_DRAIN  = 8'h41; // A
  localparam logic [7:0] LTR_CHUNK  = 8'h6B; // k
  localparam logic [7:0] LTR_RANDOM = 8'h52; // R
  localparam logic [7:0] LTR_CLOSE  = 8'h43; // C
  localparam logic [7:0] LTR_KEEP   = 8'h4B; // K

  localparam logic [4:0] DIG_NONE = 5'h1F;

  localparam logic [6:0] SHIFT_K   = 7'd10;
  localparam logic [6:0] SHIFT_M   = 7'd20;
  localparam logic [6:0] SHIFT_G   = 7'd30;
  localparam logic [6:0] SHIFT_MAX = 7'd63;

  localparam logic [63:0] SAT_MAG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_DEC = 64'd922337203685477580;
  localparam logic [63:0] LIM_OCT = 64'h1000_0000_0000_0000;
  localparam logic [63:0] LIM_HEX = 64'h0800_0000_0000_0000;

  localparam logic [2:0] KA_V11    = 3'b100;
  localparam logic [2:0] KA_FORCED = 3'b010;

  localparam logic [31:0] CODE_DEFAULT  = 32'd200;
  localparam logic [31:0] CACHE_DEFAULT = 32'd1;

  // Control travelling with one byte down the pipeline
  typedef struct packed {
    logic       defaults;
    logic       v11;
    logic       commit;
    logic       emit;
    logic       help;
    logic       random;
    logic       neg;
    logic       head;
    logic [5:0] shift;
    logic [7:0] letter;
  } ctl_t;

  typedef struct packed {
    logic        help_page;
    logic [63:0] body_size;
    logic [31:0] status_code;
    logic [31:0] delay_ms;
    logic [31:0] keepalive_wait;
    logic [31:0] cacheable;
    logic        drain_first;
    logic [2:0]  keepalive_mode;
    logic        chunked_reply;
    logic        random_payload;
  } res_t;

  function automatic logic is_space(logic [7:0] c);
    is_space = c inside {CH_SPACE, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    is_delim = c inside {CH_AMP, CH_SEMI, CH_SLASH, CH_QMARK, CH_COMMA};
  endfunction

  function automatic logic [4:0] digit_of(logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) begin
      digit_of = 5'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      digit_of = 5'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      digit_of = 5'(c - 8'h37);
    end else begin
      digit_of = DIG_NONE;
    end
  endfunction

  // Largest accumulator that still takes digit d without passing 2^63
  function automatic logic [63:0] sat_limit(radix_e r, logic [4:0] d);
    case (r)
      RADIX_HEX: sat_limit = (d == 5'd0) ? LIM_HEX : LIM_HEX - 64'd1;
      RADIX_OCT: sat_limit = (d == 5'd0) ? LIM_OCT : LIM_OCT - 64'd1;
      default:   sat_limit = (d == 5'd9) ? LIM_DEC - 64'd1 : LIM_DEC;
    endcase
  endfunction

  function automatic res_t res_defaults(logic v11);
    res_t r;
    r                = '0;
    r.status_code    = CODE_DEFAULT;
    r.cacheable      = CACHE_DEFAULT;
    r.keepalive_mode = v11 ? 3'd5 : 3'd0;
    res_defaults     = r;
  endfunction

endpackage

### hw/rtl/uri_query_option_parser.sv
// ----------------------------------------------------------------------------
// uri_query_option_parser
// Parses letter=number options after the first '?' of a request URI and
// emits the resulting response settings once, on the last URI byte.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Transfer                 Contents
// s_axis    in   one URI byte             uri_byte, random_sample, flags, tlast
// m_axis    out  one settings record      all settings, once per URI
//
// One byte is taken every cycle while the pipeline is not stalled; a result is
// valid once the token of the byte marked tlast has passed the scaling path:
// token register, partial products, quotient add, sign select, then shift and
// store into the result register.
// Reset (rst_ni low, asynchronous) returns the parser to the search for '?'
// with default settings. A result waiting on m_axis holds only the result
// register; the pipeline and s_axis_tready_o stall only while a second record
// reaches the store before the first is taken, and resume as soon as
// m_axis_tready_i takes it.
//
module uri_query_option_parser import uqp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [7:0] uri_byte, [38:8] random_sample, [39] zero
  input  logic [39:0]  s_axis_tdata_i,
  // [0] first_byte, [1] method_is_head, [2] version_is_11
  input  logic [2:0]   s_axis_tuser_i,
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [0] help_page, [64:1] body_size, [96:65] status_code, [128:97] delay_ms,
  // [160:129] keepalive_wait, [192:161] cacheable, [193] drain_first,
  // [196:194] keepalive_mode, [197] chunked_reply, [198] random_payload, [199] zero
  output logic [199:0] m_axis_tdata_o
);

`include "uri_query_option_parser_defines.svh"

  logic        adv;
  logic        accept;
  ctl_t        fr_ctl;
  logic [63:0] fr_accum;
  logic [30:0] fr_rnd;
  logic        fr_emitted;
  ctl_t        sc_ctl;
  logic [63:0] sc_val;
  res_t        res;

  // Advance the whole pipeline unless a new record would land on a waiting one
  assign adv             = !(m_axis_tvalid_o && !m_axis_tready_i && sc_ctl.emit);
  assign s_axis_tready_o = adv;
  assign accept          = s_axis_tvalid_i && adv;

  // Byte parser: phase machine and the number being read
  uqp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .accept_i  (accept),
    .byte_i    (s_axis_tdata_i[7:0]),
    .first_i   (s_axis_tuser_i[0]),
    .last_i    (s_axis_tlast_i),
    .head_i    (s_axis_tuser_i[1]),
    .v11_i     (s_axis_tuser_i[2]),
    .rnd_i     (s_axis_tdata_i[38:8]),
    .ctl_o     (fr_ctl),
    .accum_o   (fr_accum),
    .rnd_o     (fr_rnd),
    .emitted_o (fr_emitted)
  );

  // Value of a committed number, random scaling included
  uqp_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .ctl_i   (fr_ctl),
    .accum_i (fr_accum),
    .rnd_i   (fr_rnd),
    .ctl_o   (sc_ctl),
    .val_o   (sc_val)
  );

  // Apply defaults and commits in byte order, capture the record on emit
  uqp_settings u_settings (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .ctl_i       (sc_ctl),
    .val_i       (sc_val),
    .res_ready_i (m_axis_tready_i),
    .res_valid_o (m_axis_tvalid_o),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {1'b0, res.random_payload, res.chunked_reply, res.keepalive_mode,
                           res.drain_first, res.cacheable, res.keepalive_wait,
                           res.delay_ms, res.status_code, res.body_size, res.help_page};

  // A transfer with tlast always closes the URI in the parser
  `UQP_ASSERT_NEXT(a_last_closes_uri, accept && s_axis_tlast_i, fr_emitted, "URI left open")

  // A held pipeline keeps the value stage frozen
  `UQP_ASSERT_NEXT(a_hold_keeps_value, !adv, $stable(sc_val) && $stable(sc_ctl), "value moved")

  // An emit token reaching the store produces a result
  `UQP_ASSERT_NEXT(a_emit_gives_result, adv && sc_ctl.emit, m_axis_tvalid_o, "no result")

  // Nothing leaves the parser for a closed URI unless a new one starts
  `UQP_ASSERT_NEXT(a_no_commit_after_close, fr_emitted && accept && !s_axis_tuser_i[0], !fr_ctl.commit && !fr_ctl.emit, "commit after close")

endmodule

### hw/rtl/uqp_front.sv
// ----------------------------------------------------------------------------
// uqp_front
// Per-byte parse state machine; issues one control token per accepted byte.
// ----------------------------------------------------------------------------
module uqp_front import uqp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        accept_i,
  input  logic [7:0]  byte_i,
  input  logic        first_i,
  input  logic        last_i,
  input  logic        head_i,
  input  logic        v11_i,
  input  logic [30:0] rnd_i,
  output ctl_t        ctl_o,
  output logic [63:0] accum_o,
  output logic [30:0] rnd_o,
  output logic        emitted_o
);

  phase_e      phase_q, phase_d;
  radix_e      radix_q, radix_d;
  logic [7:0]  letter_q, letter_d;
  logic [63:0] accum_q, accum_d;
  logic        neg_q, neg_d;
  logic [5:0]  shift_q, shift_d;
  logic        rflag_q, rflag_d;
  logic        help_q, help_d;
  logic        emitted_q, emitted_d;
  ctl_t        ctl_q, ctl_d;
  logic [63:0] accum_out_q;
  logic [30:0] rnd_q;

  logic [4:0]  dig;
  logic        dig_ok;
  logic [63:0] acc_mul;
  logic [63:0] acc_next;
  logic        do_suffix;
  logic        commit_now;
  logic [6:0]  sh_amt;
  logic [6:0]  sh_sum;

  assign dig = digit_of(byte_i);

  // Multiply-accumulate of one digit in the current radix, saturating at 2^63
  always_comb begin
    case (radix_q)
      RADIX_HEX: begin
        dig_ok  = dig < 5'd16;
        acc_mul = {accum_q[59:0], 4'b0};
      end
      RADIX_OCT: begin
        dig_ok  = dig < 5'd8;
        acc_mul = {accum_q[60:0], 3'b0};
      end
      default: begin
        dig_ok  = dig < 5'd10;
        acc_mul = {accum_q[60:0], 3'b0} + {accum_q[62:0], 1'b0};
      end
    endcase
    acc_next = (accum_q > sat_limit(radix_q, dig)) ? SAT_MAG : acc_mul + 64'(dig);
  end

  always_comb begin
    phase_d    = phase_q;
    radix_d    = radix_q;
    letter_d   = letter_q;
    accum_d    = accum_q;
    neg_d      = neg_q;
    shift_d    = shift_q;
    rflag_d    = rflag_q;
    help_d     = help_q;
    emitted_d  = emitted_q;
    do_suffix  = 1'b0;
    commit_now = 1'b0;
    sh_amt     = 7'd0;
    sh_sum     = 7'd0;
    ctl_d      = '0;

    if (first_i) begin
      phase_d        = PH_SEEK;
      radix_d        = RADIX_DEC;
      letter_d       = 8'd0;
      accum_d        = 64'd0;
      neg_d          = 1'b0;
      shift_d        = 6'd0;
      rflag_d        = 1'b0;
      help_d         = 1'b0;
      emitted_d      = 1'b0;
      ctl_d.defaults = 1'b1;
    end

    if (!emitted_d) begin
      case (phase_d)
        PH_SEEK: begin
          if (byte_i == CH_QMARK) begin
            phase_d = PH_AFTERQ;
          end else if (byte_i == CH_NUL) begin
            phase_d = PH_DONE;
          end
        end
        PH_AFTERQ: begin
          if (byte_i == CH_SPACE) begin
            help_d  = 1'b1;
            phase_d = PH_DONE;
          end else begin
            letter_d = byte_i;
            phase_d  = PH_EQ;
          end
        end
        PH_LETTER: begin
          letter_d = byte_i;
          phase_d  = PH_EQ;
        end
        PH_EQ: begin
          if (byte_i == CH_EQ) begin
            accum_d = 64'd0;
            neg_d   = 1'b0;
            radix_d = RADIX_DEC;
            shift_d = 6'd0;
            rflag_d = 1'b0;
            phase_d = PH_NFIRST;
          end else begin
            phase_d = PH_DONE;
          end
        end
        PH_NFIRST, PH_NWS, PH_NSIGN: begin
          // accumulator is still zero here, so a first digit simply loads
          if (phase_d != PH_NSIGN && is_space(byte_i)) begin
            phase_d = PH_NWS;
          end else if (phase_d != PH_NSIGN &&
                       (byte_i == CH_PLUS || byte_i == CH_MINUS)) begin
            neg_d   = byte_i == CH_MINUS;
            phase_d = PH_NSIGN;
          end else if (byte_i == CH_ZERO) begin
            radix_d = RADIX_OCT;
            phase_d = PH_NZERO;
          end else if (byte_i inside {[CH_ZERO:CH_NINE]}) begin
            radix_d = RADIX_DEC;
            accum_d = 64'(dig);
            phase_d = PH_NDIG;
          end else if (phase_d == PH_NFIRST && is_delim(letter_d) && byte_i == CH_EQ) begin
            // a delimiter used as a letter, then '=': '=' becomes the letter
            letter_d = CH_EQ;
            accum_d  = 64'd0;
            neg_d    = 1'b0;
            radix_d  = RADIX_DEC;
            shift_d  = 6'd0;
            rflag_d  = 1'b0;
            phase_d  = PH_NFIRST;
          end else begin
            phase_d = PH_DONE;
          end
        end
        PH_NZERO: begin
          if (byte_i == CH_X_LO || byte_i == CH_X_UP) begin
            phase_d = PH_NHEX0;
          end else if (dig < 5'd8) begin
            accum_d = 64'(dig);
            phase_d = PH_NDIG;
          end else begin
            do_suffix = 1'b1;
          end
        end
        PH_NHEX0: begin
          if (dig < 5'd16) begin
            radix_d = RADIX_HEX;
            accum_d = 64'(dig);
            phase_d = PH_NDIG;
          end else begin
            commit_now = 1'b1;
            phase_d    = PH_DONE;
          end
        end
        PH_NDIG: begin
          if (dig_ok) begin
            accum_d = acc_next;
          end else begin
            do_suffix = 1'b1;
          end
        end
        PH_SUFFIX: do_suffix = 1'b1;
        default: ;
      endcase

      if (do_suffix) begin
        phase_d = PH_SUFFIX;
        if (byte_i inside {CH_K_LO, CH_K_UP}) begin
          sh_amt = SHIFT_K;
        end else if (byte_i inside {CH_M_LO, CH_M_UP}) begin
          sh_amt = SHIFT_M;
        end else if (byte_i inside {CH_G_LO, CH_G_UP}) begin
          sh_amt = SHIFT_G;
        end else if (byte_i inside {CH_R_LO, CH_R_UP}) begin
          rflag_d = 1'b1;
        end else begin
          commit_now = 1'b1;
          phase_d    = is_delim(byte_i) ? PH_LETTER : PH_DONE;
        end
        sh_sum  = {1'b0, shift_d} + sh_amt;
        shift_d = (sh_sum > SHIFT_MAX) ? SHIFT_MAX[5:0] : sh_sum[5:0];
      end

      if (last_i) begin
        if (phase_d == PH_AFTERQ) begin
          help_d = 1'b1;
        end else if (phase_d inside {PH_NZERO, PH_NHEX0, PH_NDIG, PH_SUFFIX}) begin
          commit_now = 1'b1;
        end
        phase_d    = PH_DONE;
        emitted_d  = 1'b1;
        ctl_d.emit = 1'b1;
      end
    end

    ctl_d.v11    = v11_i;
    ctl_d.commit = commit_now;
    ctl_d.help   = help_d;
    ctl_d.random = rflag_d;
    ctl_d.neg    = neg_d;
    ctl_d.head   = head_i;
    ctl_d.shift  = shift_d;
    ctl_d.letter = letter_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SEEK;
      radix_q   <= RADIX_DEC;
      letter_q  <= 8'd0;
      accum_q   <= 64'd0;
      neg_q     <= 1'b0;
      shift_q   <= 6'd0;
      rflag_q   <= 1'b0;
      help_q    <= 1'b0;
      emitted_q <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      radix_q   <= radix_d;
      letter_q  <= letter_d;
      accum_q   <= accum_d;
      neg_q     <= neg_d;
      shift_q   <= shift_d;
      rflag_q   <= rflag_d;
      help_q    <= help_d;
      emitted_q <= emitted_d;
    end
  end

  // Token register: a bubble carries no action
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= accept_i ? ctl_d : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      accum_out_q <= accum_d;
      rnd_q       <= rnd_i;
    end
  end

  assign ctl_o     = ctl_q;
  assign accum_o   = accum_out_q;
  assign rnd_o     = rnd_q;
  assign emitted_o = emitted_q;

endmodule

### hw/rtl/uqp_scale.sv
// ----------------------------------------------------------------------------
// uqp_scale
// Signed value of a committed number, with optional scaling by rnd/2^31.
// ----------------------------------------------------------------------------
module uqp_scale import uqp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  ctl_t        ctl_i,
  input  logic [63:0] accum_i,
  input  logic [30:0] rnd_i,
  output ctl_t        ctl_o,
  output logic [63:0] val_o
);

  logic [63:0] v_d;
  logic [63:0] mag;
  logic [63:0] phi_d;
  logic [61:0] plo_d;
  ctl_t        c2_d;

  ctl_t        c2_q, c3_q, c4_q;
  logic [63:0] v2_q, v3_q;
  logic [63:0] phi_q;
  logic [61:0] plo_q;
  logic [63:0] q_d, q_q;
  logic [63:0] val_d, val_q;

  // Stage 2: plain value and partial products of the magnitude
  always_comb begin
    v_d      = ctl_i.neg ? (64'd0 - accum_i) : (accum_i[63] ? SAT_POS : accum_i);
    mag      = ctl_i.neg ? accum_i : v_d;
    phi_d    = 64'(mag[63:31]) * 64'(rnd_i);
    plo_d    = 62'(mag[30:0]) * 62'(rnd_i);
    c2_d     = ctl_i;
    c2_d.neg = v_d[63];
  end

  // Stage 3: truncated quotient, stage 4: sign and select
  assign q_d   = phi_q + 64'(plo_q[61:31]);
  assign val_d = c3_q.random ? (c3_q.neg ? (64'd0 - q_q) : q_q) : v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
    end else if (adv_i) begin
      c2_q <= c2_d;
      c3_q <= c2_q;
      c4_q <= c3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      v2_q  <= v_d;
      phi_q <= phi_d;
      plo_q <= plo_d;
      v3_q  <= v2_q;
      q_q   <= q_d;
      val_q <= val_d;
    end
  end

  assign ctl_o = c4_q;
  assign val_o = val_q;

endmodule

### hw/rtl/uqp_settings.sv
// ----------------------------------------------------------------------------
// uqp_settings
// Settings registers, option store and the result register.
// ----------------------------------------------------------------------------
module uqp_settings import uqp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  ctl_t        ctl_i,
  input  logic [63:0] val_i,
  input  logic        res_ready_i,
  output logic        res_valid_o,
  output res_t        res_o
);

  res_t        set_q, set_d;
  res_t        res_q;
  logic        res_valid_q;
  logic [63:0] shifted;
  logic        nz;

  assign shifted = val_i << ctl_i.shift;
  assign nz      = val_i != 64'd0;

  always_comb begin
    set_d = set_q;
    if (ctl_i.defaults) begin
      set_d = res_defaults(ctl_i.v11);
    end
    if (ctl_i.commit) begin
      case (ctl_i.letter)
        LTR_SIZE: begin
          if (!ctl_i.head) begin
            set_d.body_size = shifted;
          end
        end
        LTR_CODE:   set_d.status_code    = shifted[31:0];
        LTR_DELAY:  set_d.delay_ms       = shifted[31:0];
        LTR_WAIT:   set_d.keepalive_wait = shifted[31:0];
        LTR_CACHE:  set_d.cacheable      = shifted[31:0];
        LTR_DRAIN:  set_d.drain_first    = nz;
        LTR_CHUNK:  set_d.chunked_reply  = nz;
        LTR_RANDOM: set_d.random_payload = nz;
        LTR_CLOSE:
          set_d.keepalive_mode = (set_d.keepalive_mode & KA_V11) | KA_FORCED | {2'b0, !nz};
        LTR_KEEP:
          set_d.keepalive_mode = (set_d.keepalive_mode & KA_V11) | KA_FORCED | {2'b0, nz};
        default: ;
      endcase
    end
    set_d.help_page = ctl_i.help;
  end

  // Hold the record until it is taken; a new emit may replace it on that edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_q       <= res_defaults(1'b0);
      res_valid_q <= 1'b0;
    end else begin
      if (adv_i) begin
        set_q <= set_d;
      end
      if (adv_i && ctl_i.emit) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && ctl_i.emit) begin
      res_q <= set_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
